/* hdl/cbm_pkg.sv */
// shared types and constants for the cartridge bank mapper
`default_nettype none
package cbm_pkg;

	localparam int BANK_ENTRIES = 11;
	localparam int IDX_W        = 4;

	// bank store layout: pattern banks 0-7, program banks 8-10
	localparam logic [IDX_W-1:0] IDX_PRG0 = 4'd8;
	localparam logic [IDX_W-1:0] IDX_PRG1 = 4'd9;
	localparam logic [IDX_W-1:0] IDX_PRG2 = 4'd10;

	// transaction kinds on the input tuser
	localparam logic [1:0] OP_REG_WRITE = 2'd0;
	localparam logic [1:0] OP_CPU_MAP   = 2'd1;
	localparam logic [1:0] OP_PPU_MAP   = 2'd2;
	localparam logic [1:0] OP_TICK      = 2'd3;

	// cpu register groups selected by a14..a13
	localparam logic [1:0] REG_BANK   = 2'd0;
	localparam logic [1:0] REG_MIRROR = 2'd1;
	localparam logic [1:0] REG_IRQ    = 2'd2;
	localparam logic [1:0] REG_ENABLE = 2'd3;

	typedef enum logic [1:0] {
		XL_NONE,
		XL_CPU,
		XL_PPU
	} xl_kind_t;

	// stage 1 control passed from decode to address formation
	typedef struct packed {
		logic        valid;
		xl_kind_t    kind;
		logic        map_ok;
		logic        fixed;
		logic        pair_mode;
		logic        slot_lo;
		logic [12:0] offset;
		logic        irq;
		logic        mirror;
	} s1_ctl_t;

	// 1K mode slot table for the lower pattern half
	function automatic logic [IDX_W-1:0] one_k_index(input logic [1:0] slot);
		logic [IDX_W-1:0] r;
		case (slot)
			2'd0: r = 4'd0;
			2'd1: r = 4'd6;
			2'd2: r = 4'd1;
			2'd3: r = 4'd7;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/cartridge_bank_mapper_with_scanline_irq.sv */
// a transaction goes through stage 1 and the bank store read, then the output register
// throughput: one transaction per cycle unless m_tready stalls; one bank read a cycle
// a register write is seen by the next transaction through the bank store write port
// reset clears all mapper registers, the bank store valid bits and the pipeline
// never-written bank entries read as their reset numbers; masks reset to 63 and 255
`default_nettype none
module cartridge_bank_mapper_with_scanline_irq
	import cbm_pkg::*;
#(
	parameter int PRG_BANK_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // bus_addr[15:0], wdata[23:16], tick_source[24]
	input  wire logic [1:0]  s_tuser,  // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // mapped_addr[20:0], mapped_valid[21], irq_line[22],
	                                   // mirror_horizontal[23]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic             fire;
	logic             s1_take;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	logic [7:0]       bank_rd;
	s1_ctl_t          ctl_s1;
	logic [7:0]       prg_bank_mask_q;
	logic [7:0]       chr_bank_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_mask_q <= 8'd63;
			chr_bank_mask_q <= 8'd255;
		end else if (cfg_valid) begin
			if (cfg_index) chr_bank_mask_q <= cfg_data;
			else           prg_bank_mask_q <= cfg_data;
		end
	end

	assign s_tready = !ctl_s1.valid || s1_take;
	assign fire     = s_tvalid && s_tready;

	cbm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.s1_take     (s1_take),
		.op          (s_tuser),
		.bus_addr    (s_tdata[15:0]),
		.wdata       (s_tdata[23:16]),
		.tick_source (s_tdata[24]),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_raddr   (mem_raddr),
		.ctl_s1      (ctl_s1)
	);

	cbm_bank_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (s_tdata[23:16]),
		.re     (fire),
		.raddr  (mem_raddr),
		.rdata  (bank_rd)
	);

	cbm_xlate #(
		.PRG_BANK_COUNT (PRG_BANK_COUNT)
	) u_xlate (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s1        (ctl_s1),
		.bank_rd       (bank_rd),
		.prg_bank_mask (prg_bank_mask_q),
		.chr_bank_mask (chr_bank_mask_q),
		.s1_take       (s1_take),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata)
	);

endmodule
`default_nettype wire

/* hdl/cbm_bank_ram.sv */
// bank number store with registered read and reset-value valid bits
`default_nettype none
module cbm_bank_ram
	import cbm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output logic [7:0]            rdata
);

	logic [7:0]             bank_mem [BANK_ENTRIES];
	logic [BANK_ENTRIES-1:0] written_q;
	logic [7:0]             rd_q;
	logic                   rd_vld_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [IDX_W-1:0]       def_idx;

	always_ff @(posedge clk) begin
		if (we) begin
			bank_mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q     <= bank_mem[raddr];
			rd_idx_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= written_q[raddr];
			end
		end
	end

	// an entry never written reads as its own index within its group
	assign def_idx = (rd_idx_q < IDX_PRG0) ? rd_idx_q : rd_idx_q - IDX_PRG0;
	assign rdata   = rd_vld_q ? rd_q : {{(8 - IDX_W){1'b0}}, def_idx};

endmodule
`default_nettype wire

/* hdl/cbm_ctrl.sv */
// register decode, irq counter and bank lookup issue
`default_nettype none
module cbm_ctrl
	import cbm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             s1_take,
	input  wire logic [1:0]       op,
	input  wire logic [15:0]      bus_addr,
	input  wire logic [7:0]       wdata,
	input  wire logic             tick_source,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output logic [IDX_W-1:0]      mem_raddr,
	output s1_ctl_t               ctl_s1
);

	logic [7:0] bank_control_q;
	logic       mirror_q;
	logic [7:0] latch_q;
	logic [8:0] counter_q;
	logic       pending_q;
	logic       enable_q;
	logic       clk_sel_q;
	logic       flag_q;

	logic [7:0] bank_control_d;
	logic       mirror_d;
	logic [7:0] latch_d;
	logic [8:0] counter_d;
	logic       pending_d;
	logic       enable_d;
	logic       clk_sel_d;
	logic       flag_d;

	logic [1:0]  reg_grp;
	logic        odd;
	logic [3:0]  sel;
	logic [12:0] ppu_a;
	logic [2:0]  slot;
	s1_ctl_t     ctl_d;

	assign reg_grp = bus_addr[14:13];
	assign odd     = bus_addr[0];
	assign sel     = bank_control_q[3:0];
	assign ppu_a   = bus_addr[12:0] ^ {bank_control_q[7], 12'd0};
	assign slot    = ppu_a[12:10];

	// bank data write target
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		if (fire && op == OP_REG_WRITE && bus_addr[15] && reg_grp == REG_BANK && odd) begin
			if (sel < 4'd6) begin
				mem_we    = 1'b1;
				mem_waddr = sel;
			end else if (sel == 4'd6 || sel == 4'd7) begin
				mem_we    = 1'b1;
				mem_waddr = sel + 4'd2;
			end else if (sel == 4'd8 || sel == 4'd9) begin
				mem_we    = 1'b1;
				mem_waddr = sel - 4'd2;
			end else if (sel == 4'd15) begin
				mem_we    = 1'b1;
				mem_waddr = IDX_PRG2;
			end
		end
	end

	// register and counter next state
	always_comb begin
		bank_control_d = bank_control_q;
		mirror_d       = mirror_q;
		latch_d        = latch_q;
		counter_d      = counter_q;
		pending_d      = pending_q;
		enable_d       = enable_q;
		clk_sel_d      = clk_sel_q;
		flag_d         = flag_q;
		case (op)
			OP_REG_WRITE: begin
				if (bus_addr[15]) begin
					case (reg_grp)
						REG_BANK: begin
							if (!odd) bank_control_d = wdata;
						end
						REG_MIRROR: begin
							if (!odd) mirror_d = wdata[0];
						end
						REG_IRQ: begin
							if (odd) begin
								pending_d = 1'b1;
								clk_sel_d = wdata[0];
							end else begin
								latch_d = wdata;
							end
						end
						default: begin
							if (odd) begin
								enable_d = 1'b1;
							end else begin
								enable_d = 1'b0;
								flag_d   = 1'b0;
							end
						end
					endcase
				end
			end
			OP_TICK: begin
				if (tick_source == clk_sel_q) begin
					if (pending_q) begin
						pending_d = 1'b0;
						counter_d = {1'b0, latch_q} + 9'd1;
					end else if (counter_q == 9'd0) begin
						counter_d = {1'b0, latch_q};
					end else begin
						counter_d = counter_q - 9'd1;
						if (counter_q == 9'd1 && enable_q) flag_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// bank lookup address and stage 1 control
	always_comb begin
		mem_raddr       = '0;
		ctl_d.valid     = 1'b1;
		ctl_d.kind      = XL_NONE;
		ctl_d.map_ok    = 1'b0;
		ctl_d.fixed     = 1'b0;
		ctl_d.pair_mode = 1'b0;
		ctl_d.slot_lo   = slot[0];
		ctl_d.offset    = bus_addr[12:0];
		ctl_d.irq       = flag_d;
		ctl_d.mirror    = mirror_d;
		case (op)
			OP_CPU_MAP: begin
				ctl_d.kind   = XL_CPU;
				ctl_d.map_ok = bus_addr[15];
				case (bus_addr[14:13])
					2'd0: mem_raddr = bank_control_q[6] ? IDX_PRG2 : IDX_PRG0;
					2'd1: mem_raddr = bank_control_q[6] ? IDX_PRG0 : IDX_PRG1;
					2'd2: mem_raddr = bank_control_q[6] ? IDX_PRG1 : IDX_PRG2;
					default: ctl_d.fixed = 1'b1;
				endcase
			end
			OP_PPU_MAP: begin
				ctl_d.kind   = XL_PPU;
				ctl_d.map_ok = (bus_addr[15:13] == 3'd0);
				ctl_d.offset = ppu_a;
				if (!slot[2]) begin
					if (bank_control_q[5]) begin
						mem_raddr = one_k_index(slot[1:0]);
					end else begin
						ctl_d.pair_mode = 1'b1;
						mem_raddr       = {{(IDX_W - 1){1'b0}}, slot[1]};
					end
				end else begin
					mem_raddr = {1'b0, slot} - 4'd2;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_control_q <= '0;
			mirror_q       <= 1'b0;
			latch_q        <= '0;
			counter_q      <= '0;
			pending_q      <= 1'b0;
			enable_q       <= 1'b0;
			clk_sel_q      <= 1'b0;
			flag_q         <= 1'b0;
			ctl_s1         <= '0;
		end else begin
			if (fire) begin
				bank_control_q <= bank_control_d;
				mirror_q       <= mirror_d;
				latch_q        <= latch_d;
				counter_q      <= counter_d;
				pending_q      <= pending_d;
				enable_q       <= enable_d;
				clk_sel_q      <= clk_sel_d;
				flag_q         <= flag_d;
				ctl_s1         <= ctl_d;
			end else if (s1_take) begin
				ctl_s1.valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/cbm_xlate.sv */
// final address formation and output register
`default_nettype none
module cbm_xlate
	import cbm_pkg::*;
#(
	parameter int PRG_BANK_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire s1_ctl_t     ctl_s1,
	input  wire logic [7:0]  bank_rd,
	input  wire logic [7:0]  prg_bank_mask,
	input  wire logic [7:0]  chr_bank_mask,
	output logic             s1_take,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [23:0]      m_tdata
);

	localparam logic [7:0] LAST_BANK = 8'(PRG_BANK_COUNT - 1);

	logic [7:0]  bank;
	logic [20:0] mapped;
	logic        out_valid_q;
	logic [23:0] out_data_q;

	always_comb begin
		bank = ctl_s1.pair_mode ? {bank_rd[7:1], ctl_s1.slot_lo} : bank_rd;
		if (ctl_s1.fixed) bank = LAST_BANK;
		mapped = '0;
		if (ctl_s1.map_ok) begin
			case (ctl_s1.kind)
				XL_CPU:  mapped = {bank & prg_bank_mask, ctl_s1.offset};
				XL_PPU:  mapped = {3'd0, bank & chr_bank_mask, ctl_s1.offset[9:0]};
				default: mapped = '0;
			endcase
		end
	end

	assign s1_take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && ctl_s1.valid) begin
			out_data_q <= {ctl_s1.mirror, ctl_s1.irq, ctl_s1.map_ok, mapped};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

/* bench/mapper_tb_pkg.sv */
// bench-side codes and result layout shared by the mapper checker and the stimulus
`timescale 1ns / 100ps
package mapper_tb_pkg;

	// configuration register indexes
	localparam logic CFG_PRG_MASK = 1'b0;
	localparam logic CFG_CHR_MASK = 1'b1;

	// bank control bits
	localparam logic [7:0] CTL_CHR_INVERT = 8'h80;
	localparam logic [7:0] CTL_PRG_SWAP   = 8'h40;
	localparam logic [7:0] CTL_CHR_1K     = 8'h20;

	// bank data selectors in control bits 3..0
	localparam logic [3:0] SEL_PRG0       = 4'd6;
	localparam logic [3:0] SEL_PRG1       = 4'd7;
	localparam logic [3:0] SEL_CHR6       = 4'd8;
	localparam logic [3:0] SEL_CHR7       = 4'd9;
	localparam logic [3:0] SEL_UNUSED_LO  = 4'd10;
	localparam logic [3:0] SEL_UNUSED_HI  = 4'd14;
	localparam logic [3:0] SEL_PRG2       = 4'd15;

	// one output transaction, lowest field last
	typedef struct packed {
		logic        mirror_horizontal;
		logic        irq_line;
		logic        mapped_valid;
		logic [20:0] mapped_addr;
	} map_result_t;

endpackage

/* bench/mapper_checker.sv */
// watches the mapper channels, predicts every result and compares it
`timescale 1ns / 100ps
module mapper_checker
	import cbm_pkg::*;
	import mapper_tb_pkg::*;
#(
	parameter int PRG_BANK_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,  // bus_addr[15:0], wdata[23:16], tick_source[24]
	input  wire logic [1:0]  s_tuser,  // op[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,  // mapped_addr[20:0], mapped_valid[21], irq_line[22],
	                                   // mirror_horizontal[23]
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               errors,
	output int               outstanding
);

	logic [7:0] prg_mask;
	logic [7:0] chr_mask;
	logic [7:0] bank_ctl;
	logic [7:0] chr_bank [8];
	logic [7:0] prg_bank [3];
	logic       mirror;
	logic [7:0] irq_latch;
	logic [8:0] irq_count;
	logic       reload_pend;
	logic       irq_en;
	logic       irq_src;
	logic       irq_pend;

	map_result_t expected_results[$];

	task automatic clear_mapper();
		prg_mask    = 8'd63;
		chr_mask    = 8'd255;
		bank_ctl    = '0;
		for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
		for (int i = 0; i < 3; i++) prg_bank[i] = 8'(i);
		mirror      = 1'b0;
		irq_latch   = '0;
		irq_count   = '0;
		reload_pend = 1'b0;
		irq_en      = 1'b0;
		irq_src     = 1'b0;
		irq_pend    = 1'b0;
	endtask

	task automatic write_bank_data(input logic [7:0] d);
		logic [3:0] sel;
		sel = bank_ctl[3:0];
		if (sel < SEL_PRG0)
			chr_bank[sel[2:0]] = d;
		else if (sel == SEL_PRG0 || sel == SEL_PRG1)
			prg_bank[sel - SEL_PRG0] = d;
		else if (sel == SEL_CHR6 || sel == SEL_CHR7)
			chr_bank[sel - 4'd2] = d;
		else if (sel == SEL_PRG2)
			prg_bank[2] = d;
	endtask

	task automatic predict_mapper(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] d, input logic src, output map_result_t r);
		logic [7:0]  bank;
		logic [12:0] pa;
		logic [2:0]  slot;
		logic        swap;
		r = '0;
		swap = (bank_ctl & CTL_PRG_SWAP) != 0;
		case (op)
			OP_REG_WRITE: begin
				if (addr[15]) begin
					case (addr[14:13])
						REG_BANK: begin
							if (addr[0]) write_bank_data(d);
							else bank_ctl = d;
						end
						REG_MIRROR: begin
							if (!addr[0]) mirror = d[0];
						end
						REG_IRQ: begin
							if (addr[0]) begin
								reload_pend = 1'b1;
								irq_src     = d[0];
							end else begin
								irq_latch = d;
							end
						end
						default: begin
							if (addr[0]) begin
								irq_en = 1'b1;
							end else begin
								irq_en   = 1'b0;
								irq_pend = 1'b0;
							end
						end
					endcase
				end
			end
			OP_CPU_MAP: begin
				if (addr[15]) begin
					case (addr[14:13])
						2'd0:    bank = swap ? prg_bank[2] : prg_bank[0];
						2'd1:    bank = swap ? prg_bank[0] : prg_bank[1];
						2'd2:    bank = swap ? prg_bank[1] : prg_bank[2];
						default: bank = 8'(PRG_BANK_COUNT - 1);
					endcase
					bank = bank & prg_mask;
					r.mapped_addr  = {bank, addr[12:0]};
					r.mapped_valid = 1'b1;
				end
			end
			OP_PPU_MAP: begin
				if (addr[15:13] == 3'd0) begin
					// control bit 7 swaps the two 4K halves
					pa   = addr[12:0] ^ {bank_ctl[7], 12'd0};
					slot = pa[12:10];
					if (!slot[2]) begin
						if ((bank_ctl & CTL_CHR_1K) != 0) begin
							case (slot[1:0])
								2'd0: bank = chr_bank[0];
								2'd1: bank = chr_bank[6];
								2'd2: bank = chr_bank[1];
								default: bank = chr_bank[7];
							endcase
						end else begin
							bank = {chr_bank[slot[1]][7:1], slot[0]};
						end
					end else begin
						bank = chr_bank[slot - 3'd2];
					end
					bank = bank & chr_mask;
					r.mapped_addr  = {3'd0, bank, pa[9:0]};
					r.mapped_valid = 1'b1;
				end
			end
			default: begin
				if (src == irq_src) begin
					if (reload_pend) begin
						reload_pend = 1'b0;
						irq_count   = {1'b0, irq_latch} + 9'd1;
					end else if (irq_count == 9'd0) begin
						irq_count = {1'b0, irq_latch};
					end else begin
						irq_count = irq_count - 9'd1;
						if (irq_count == 9'd0 && irq_en) irq_pend = 1'b1;
					end
				end
			end
		endcase
		r.irq_line          = irq_pend;
		r.mirror_horizontal = mirror;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		map_result_t got;
		map_result_t want;
		if (!arst_n) begin
			clear_mapper();
			expected_results.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					errors++;
					$error("result transaction with none expected: 0x%06h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("mapped_addr", want.mapped_addr, got.mapped_addr);
					check_field("mapped_valid", want.mapped_valid, got.mapped_valid);
					check_field("irq_line", want.irq_line, got.irq_line);
					check_field("mirror_horizontal", want.mirror_horizontal,
						got.mirror_horizontal);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PRG_MASK) prg_mask = cfg_data;
				else chr_mask = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_mapper(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[24], want);
				expected_results.push_back(want);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

/* bench/tb.sv */
// stimulus and verdict for the cartridge bank mapper with scanline irq
`timescale 1ns / 100ps
module tb;
	import cbm_pkg::*;
	import mapper_tb_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	int errors;
	int outstanding;
	int cycle_count = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 83;

	cartridge_bank_mapper_with_scanline_irq i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mapper_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cartridge_bank_mapper_with_scanline_irq test failed");
			$finish;
		end
	end

	function automatic logic [15:0] reg_addr(input logic [1:0] group, input logic odd);
		return {1'b1, group, 12'd0, odd};
	endfunction

	task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] d,
			input logic src);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, src, d, addr};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every outstanding result drain
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  d;
		logic        src;
		int          pick;
		int          sel;
		pick = $urandom_range(99);
		op   = OP_REG_WRITE;
		addr = 16'($urandom);
		d    = 8'($urandom);
		src  = 1'($urandom);
		if (pick < 8) begin
			// noise: any op, any address
			op = 2'($urandom);
		end else if (pick < 40) begin
			addr[15] = 1'b1;
			case ($urandom_range(6))
				0: begin
					addr[14:13] = REG_BANK;
					addr[0] = 1'b0;
					sel = $urandom_range(11);
					if (sel < 10) d[3:0] = 4'(sel);
					else if (sel == 10) d[3:0] = SEL_PRG2;
					else d[3:0] = 4'($urandom_range(SEL_UNUSED_LO, SEL_UNUSED_HI));
				end
				1: begin
					addr[14:13] = REG_BANK;
					addr[0] = 1'b1;
				end
				2: addr[14:13] = REG_MIRROR;
				3: begin
					addr[14:13] = REG_IRQ;
					addr[0] = 1'b0;
					// short latch values so the counter reaches zero often
					if ($urandom_range(3) != 0) d = 8'($urandom_range(6));
				end
				4: begin
					addr[14:13] = REG_IRQ;
					addr[0] = 1'b1;
					d[0] = ($urandom_range(3) == 0);
				end
				5: begin
					addr[14:13] = REG_ENABLE;
					addr[0] = 1'b0;
				end
				default: begin
					addr[14:13] = REG_ENABLE;
					addr[0] = 1'b1;
				end
			endcase
		end else if (pick < 60) begin
			op = OP_CPU_MAP;
			if ($urandom_range(7) != 0) addr[15] = 1'b1;
		end else if (pick < 78) begin
			op = OP_PPU_MAP;
			if ($urandom_range(7) != 0) addr[15:13] = 3'd0;
		end else begin
			op  = OP_TICK;
			src = ($urandom_range(3) == 0);
		end
		send(op, addr, d, src);
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) send_random();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// translations with reset banks, inside and outside the windows
		send(OP_CPU_MAP, 16'h7FFF, 8'h00, 1'b0);
		send(OP_CPU_MAP, 16'h8000, 8'hFF, 1'b1);
		send(OP_CPU_MAP, 16'hA000, 8'h00, 1'b0);
		send(OP_CPU_MAP, 16'hC000, 8'h00, 1'b0);
		send(OP_CPU_MAP, 16'hFFFF, 8'h00, 1'b0);
		send(OP_PPU_MAP, 16'h0000, 8'h00, 1'b0);
		send(OP_PPU_MAP, 16'h1FFF, 8'h00, 1'b0);
		send(OP_PPU_MAP, 16'h2000, 8'h00, 1'b0);
		// write below the register space is ignored
		send(OP_REG_WRITE, 16'h7FFF, 8'hFF, 1'b0);
		// unused selector drops the bank data write
		send(OP_REG_WRITE, reg_addr(REG_BANK, 1'b0), {4'd0, SEL_UNUSED_LO}, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_BANK, 1'b1), 8'hFF, 1'b0);
		// all mode bits set, last program bank register written
		send(OP_REG_WRITE, reg_addr(REG_BANK, 1'b0),
			CTL_CHR_INVERT | CTL_PRG_SWAP | CTL_CHR_1K | {4'd0, SEL_PRG2}, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_BANK, 1'b1), 8'hFF, 1'b0);
		send(OP_CPU_MAP, 16'h8000, 8'h00, 1'b0);
		send(OP_PPU_MAP, 16'h0400, 8'h00, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_MIRROR, 1'b0), 8'h01, 1'b0);
		// odd mirroring address is not a register
		send(OP_REG_WRITE, reg_addr(REG_MIRROR, 1'b1), 8'h00, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_IRQ, 1'b0), 8'h02, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_IRQ, 1'b1), 8'h00, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_ENABLE, 1'b1), 8'h00, 1'b0);
		// tick from the other source is ignored
		send(OP_TICK, 16'h0000, 8'h00, 1'b1);
		// reload, count down to zero, raise irq, then reload from latch
		repeat (5) send(OP_TICK, 16'h0000, 8'h00, 1'b0);
		send(OP_REG_WRITE, reg_addr(REG_ENABLE, 1'b0), 8'h00, 1'b0);
		drain();

		cfg_write(CFG_PRG_MASK, 8'hFF);
		cfg_write(CFG_CHR_MASK, 8'hFF);
		random_phase(ITEMS_PER_PHASE);
		drain();

		cfg_write(CFG_PRG_MASK, 8'h00);
		cfg_write(CFG_CHR_MASK, 8'h00);
		send_idle_pct = 83;
		recv_idle_pct = 34;
		random_phase(ITEMS_PER_PHASE);
		drain();

		cfg_write(CFG_PRG_MASK, 8'($urandom));
		cfg_write(CFG_CHR_MASK, 8'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(ITEMS_PER_PHASE);
		drain();

		if (errors == 0)
			$display("cartridge_bank_mapper_with_scanline_irq test passed");
		else
			$display("cartridge_bank_mapper_with_scanline_irq test failed");
		$finish;
	end

endmodule
